### rtl/uqsd_pkg.sv
// Shared types, character constants and the hex digit helper for the URL
// query string decoder. No dependencies; every other file depends on this one.
package uqsd_pkg;

   // Characters the decoder treats specially.
   localparam logic [7:0] CHAR_PERCENT   = 8'h25;
   localparam logic [7:0] CHAR_PLUS      = 8'h2B;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_EQUALS    = 8'h3D;
   localparam logic [7:0] CHAR_AMPERSAND = 8'h26;
   localparam logic [7:0] CHAR_DIGIT_0   = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9   = 8'h39;
   localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F   = 8'h66;
   localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F   = 8'h46;

   // Offsets that map a letter digit onto its value in the low nibble.
   localparam logic [7:0] LOWER_HEX_BIAS = 8'h57;
   localparam logic [7:0] UPPER_HEX_BIAS = 8'h37;

   // Sticky error codes.
   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_NO_EQUALS = 2'd1,
      ERR_ESCAPE    = 2'd2
   } err_type;

   // Percent escape progress, one-hot.
   typedef enum logic [2:0] {
      ESC_IDLE = 3'b001,
      ESC_HIGH = 3'b010,
      ESC_LOW  = 3'b100
   } esc_state_type;

   // Payload of one input transaction.
   typedef struct packed {
      logic [7:0] in_byte;
      logic       query_last;
   } req_type;

   // Payload of one result transaction.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       in_value_part;
      logic       entry_end;
      logic       query_done;
      logic [1:0] error_code;
   } rsp_type;

   // Result of a hex digit lookup.
   typedef struct packed {
      logic       ok;
      logic [3:0] nibble;
   } hex_type;

   // Classifies one byte as a hex digit of either case and gives its value.
   function automatic hex_type hex_value(logic [7:0] c);
      hex_type    res;
      logic [7:0] diff;
      res  = '0;
      diff = '0;
      if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
         diff = c - CHAR_DIGIT_0;
         res.ok = 1'b1;
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
         diff = c - LOWER_HEX_BIAS;
         res.ok = 1'b1;
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
         diff = c - UPPER_HEX_BIAS;
         res.ok = 1'b1;
      end
      res.nibble = diff[3:0];
      return res;
   endfunction

endpackage

### rtl/uqsd_channels.sv
// Valid/ready channel interfaces for the query decoder's input and result
// streams. Depends on uqsd_pkg for the payload types.
interface uqsd_req_if;
   logic             valid;
   logic             ready;
   uqsd_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface uqsd_rsp_if;
   logic             valid;
   logic             ready;
   uqsd_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### rtl/uqsd_in_stage.sv
// Input register of the query decoder: captures one request transaction.
// Depends on uqsd_pkg and uqsd_req_if.
module uqsd_in_stage (
   input  logic              clock,
   input  logic              reset,
   uqsd_req_if.sink          req_ch,
   input  logic              advance,
   output logic              item_valid,
   output uqsd_pkg::req_type item
);
   import uqsd_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;

   // The register takes a new transaction when empty or when its item moves on.
   assign req_ch.ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (req_ch.ready) begin
         valid_in = req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload carries no reset.
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         data_ff <= req_ch.payload;
      end
   end

   assign item_valid = valid_ff;
   assign item       = data_ff;

endmodule

### rtl/uqsd_decoder.sv
// Per-byte decode logic and parser state of the query decoder.
// Depends on uqsd_pkg; state advances only when a step is taken.
module uqsd_decoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  uqsd_pkg::req_type item,
   output uqsd_pkg::rsp_type result
);
   import uqsd_pkg::*;

   logic          value_mode_ff,    value_mode_in;
   esc_state_type escape_ff,        escape_in;
   logic [3:0]    high_nibble_ff,   high_nibble_in;
   logic          entry_started_ff, entry_started_in;
   err_type       error_ff,         error_in;

   // Decode one byte against the current state and form the next state.
   always_comb begin
      hex_type       hex;
      logic          consumed;
      logic          vm;
      esc_state_type esc;
      logic [3:0]    hi;
      logic          started;
      err_type       err;
      rsp_type       res;

      hex      = hex_value(item.in_byte);
      consumed = 1'b0;
      vm       = value_mode_ff;
      esc      = escape_ff;
      hi       = high_nibble_ff;
      started  = entry_started_ff;
      err      = error_ff;
      res      = '0;

      // A pending escape takes a hex digit, or is dropped with an error.
      if (escape_ff != ESC_IDLE) begin
         if (hex.ok) begin
            if (escape_ff == ESC_HIGH) begin
               hi  = hex.nibble;
               esc = ESC_LOW;
            end else begin
               res.out_byte   = {high_nibble_ff, hex.nibble};
               res.byte_valid = 1'b1;
               esc            = ESC_IDLE;
               hi             = 4'd0;
            end
            consumed = 1'b1;
         end else begin
            if (err == ERR_NONE) begin
               err = ERR_ESCAPE;
            end
            esc = ESC_IDLE;
            hi  = 4'd0;
         end
      end

      // Raw byte handling: entry close, separator, plus and escape start.
      if (!consumed) begin
         if (item.in_byte == CHAR_AMPERSAND) begin
            if (started) begin
               if (esc != ESC_IDLE && err == ERR_NONE) begin
                  err = ERR_ESCAPE;
               end
               if (!vm && err == ERR_NONE) begin
                  err = ERR_NO_EQUALS;
               end
               res.entry_end = 1'b1;
            end
            vm      = 1'b0;
            esc     = ESC_IDLE;
            hi      = 4'd0;
            started = 1'b0;
         end else begin
            started = 1'b1;
            if (!vm) begin
               if (item.in_byte == CHAR_EQUALS) begin
                  vm = 1'b1;
               end else begin
                  res.out_byte   = item.in_byte;
                  res.byte_valid = 1'b1;
               end
            end else if (item.in_byte == CHAR_PLUS) begin
               res.out_byte   = CHAR_SPACE;
               res.byte_valid = 1'b1;
            end else if (item.in_byte == CHAR_PERCENT) begin
               esc = ESC_HIGH;
            end else begin
               res.out_byte   = item.in_byte;
               res.byte_valid = 1'b1;
            end
         end
      end

      res.in_value_part = vm;

      // The final byte closes any open entry and then clears all state.
      if (item.query_last) begin
         if (started) begin
            if (esc != ESC_IDLE && err == ERR_NONE) begin
               err = ERR_ESCAPE;
            end
            if (!vm && err == ERR_NONE) begin
               err = ERR_NO_EQUALS;
            end
            res.entry_end = 1'b1;
         end
      end
      res.query_done = item.query_last;
      res.error_code = err;

      result = res;
      if (item.query_last) begin
         value_mode_in    = 1'b0;
         escape_in        = ESC_IDLE;
         high_nibble_in   = 4'd0;
         entry_started_in = 1'b0;
         error_in         = ERR_NONE;
      end else begin
         value_mode_in    = vm;
         escape_in        = esc;
         high_nibble_in   = hi;
         entry_started_in = started;
         error_in         = err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_mode_ff    <= 1'b0;
         escape_ff        <= ESC_IDLE;
         high_nibble_ff   <= 4'd0;
         entry_started_ff <= 1'b0;
         error_ff         <= ERR_NONE;
      end else if (step) begin
         value_mode_ff    <= value_mode_in;
         escape_ff        <= escape_in;
         high_nibble_ff   <= high_nibble_in;
         entry_started_ff <= entry_started_in;
         error_ff         <= error_in;
      end
   end

`ifndef ASSERT_OFF
   // The end of a query leaves the parser in its reset state.
   a_query_end_clears: assert property (@(posedge clock) disable iff (reset)
      step && item.query_last |=> error_ff == ERR_NONE && escape_ff == ESC_IDLE
         && !entry_started_ff && !value_mode_ff)
      else $error("parser state not cleared after end of query");

   // A latched error never changes before the query ends.
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      step && error_ff != ERR_NONE && !item.query_last |=> error_ff == $past(error_ff))
      else $error("sticky error code changed within a query");

   // A step without a data byte reports a zero byte.
   a_idle_byte_zero: assert property (@(posedge clock) disable iff (reset)
      step && !result.byte_valid |-> result.out_byte == 8'd0)
      else $error("nonzero out_byte without byte_valid");

   // Nothing moves the state without a step.
   a_hold_without_step: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(error_ff) && $stable(escape_ff) && $stable(value_mode_ff))
      else $error("parser state changed without a step");
`endif

endmodule

### rtl/uqsd_out_stage.sv
// Result register of the query decoder: holds one response transaction
// until it is taken. Depends on uqsd_pkg and uqsd_rsp_if.
module uqsd_out_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  uqsd_pkg::rsp_type result,
   output logic              can_load,
   uqsd_rsp_if.source        rsp_ch
);
   import uqsd_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   // Free when empty or when the held result leaves in this cycle.
   assign can_load = !valid_ff || rsp_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (can_load) begin
         valid_in = load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_ch.valid   = valid_ff;
   assign rsp_ch.payload = data_ff;

endmodule

### rtl/url_query_string_decoder_top.sv
// Channel     | Dir | Payload                                  | Handshake
// req_ch      | in  | in_byte, query_last                      | valid/ready
// rsp_ch      | out | out_byte, byte_valid, in_value_part,      | valid/ready
//             |     | entry_end, query_done, error_code        |
//
// Each byte passes through the input register, then is decoded into the result
// register. One byte is accepted every cycle while the result is not stalled.
// The parser state updates as a byte moves from the input to the result register.
// Reset is synchronous and empties both registers and clears the parser.
// A stalled result holds the result register and a full input register; input acceptance resumes with rsp_ch.ready.
//
// Top level of the URL query string decoder. Depends on uqsd_pkg,
// the channel interfaces and the stage and decoder modules.
module url_query_string_decoder_top (
   input  logic       clock,
   input  logic       reset,
   uqsd_req_if.sink   req_ch,
   uqsd_rsp_if.source rsp_ch
);
   import uqsd_pkg::*;

   logic    item_valid;
   req_type item;
   rsp_type result;
   logic    can_load;
   logic    advance;

   // A byte moves on when the result register can take it.
   assign advance = item_valid && can_load;

   uqsd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   uqsd_decoder u_decoder (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item),
      .result (result)
   );

   uqsd_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .load     (advance),
      .result   (result),
      .can_load (can_load),
      .rsp_ch   (rsp_ch)
   );

endmodule
